>>> src/frwl_pkg.sv
// Shared types and constants for the reader-writer lock grant arbiter.
`timescale 1ns / 1ps
`default_nettype none

package frwl_pkg;

    localparam int HANDLES_DEF = 16;
    localparam int HANDLE_W    = 4;
    localparam int MASK_W      = 16;
    localparam int LEN_W       = 5;

    localparam logic MODE_JOIN  = 1'b0;
    localparam logic MODE_LEAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_JOIN_DUP     = 2'd1,
        ST_LEAVE_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [MASK_W-1:0]   new_read_grants;
        logic [MASK_W-1:0]   new_write_grants;
        logic [LEN_W-1:0]    line_length;
    } t_rsp;

endpackage

`default_nettype wire

>>> src/frwl_ifs.sv
// Request and response channel interfaces of the lock grant arbiter.
`timescale 1ns / 1ps
`default_nettype none

interface frwl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [frwl_pkg::HANDLE_W-1:0] handle;
    logic                          is_write;

    modport source (output valid, output mode, output handle, output is_write, input ready);
    modport sink   (input valid, input mode, input handle, input is_write, output ready);
endinterface

interface frwl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [frwl_pkg::MASK_W-1:0]   new_read_grants;
    logic [frwl_pkg::MASK_W-1:0]   new_write_grants;
    logic [frwl_pkg::LEN_W-1:0]    line_length;

    modport source (output valid, output status, output new_read_grants,
                    output new_write_grants, output line_length, input ready);
    modport sink   (input valid, input status, input new_read_grants,
                    input new_write_grants, input line_length, output ready);
endinterface

`default_nettype wire

>>> src/fifo_reader_writer_lock_grants_core.sv
// Top level of the first-in-first-out reader-writer lock grant arbiter.
//
// i_req carries one transaction per request: mode (join at tail or leave),
// handle and is_write. o_rsp returns exactly one transaction per request:
// status, masks of read and write grants newly given, and line length.
// Requests are handled one at a time; i_req.ready is high only while the
// sequencer is idle. Each request walks the line memory one entry at a time
// (read, then evaluate) through a single compare/update unit. A refused
// request goes straight to the finish state; a join runs the grant walk from
// the head; a leave first compacts the line, then runs the grant walk. The
// grant walk stops at the first writer. i_req.ready returns in the cycle
// after the result loads. A finished result sits in the output register;
// the next request is taken while it waits, and the sequencer holds its next
// result until the output register frees. Stalling o_rsp.ready only delays
// completion. Reset (i_rst_n low, synchronous) empties the line and clears
// all grants.
`timescale 1ns / 1ps
`default_nettype none

module fifo_reader_writer_lock_grants_core #(
    parameter int HANDLES = frwl_pkg::HANDLES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    frwl_req_if.sink   i_req,
    frwl_rsp_if.source o_rsp
);
    import frwl_pkg::*;

    logic out_free;
    logic load;
    t_rsp rsp_data;

    frwl_engine #(
        .HANDLES (HANDLES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_load     (load),
        .o_rsp      (rsp_data)
    );

    frwl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_data  (rsp_data),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

>>> src/frwl_engine.sv
// Sequencer, line memory and per-handle flags; walks the line one entry at a time.
`timescale 1ns / 1ps
`default_nettype none

module frwl_engine #(
    parameter int HANDLES = frwl_pkg::HANDLES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    frwl_req_if.sink     i_req,
    input  wire logic    i_out_free,
    output logic         o_load,
    output frwl_pkg::t_rsp o_rsp
);
    import frwl_pkg::*;

    localparam int IDX_W = $clog2(HANDLES);
    localparam int CNT_W = $clog2(HANDLES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_C_RD,
        S_C_EX,
        S_W_RD,
        S_W_EX,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_line [HANDLES];
    logic [IDX_W-1:0]    r_rdata;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_dst;
    logic [IDX_W-1:0]    r_idx;
    logic [HANDLES-1:0]  r_in_line;
    logic [HANDLES-1:0]  r_wants_write;
    logic [HANDLES-1:0]  r_rd_grant;
    logic [HANDLES-1:0]  r_wr_grant;
    t_status             r_status;
    logic [MASK_W-1:0]   r_new_rd;
    logic [MASK_W-1:0]   r_new_wr;

    logic                accept;
    logic                is_join;
    logic [IDX_W-1:0]    req_idx;
    logic                req_ok;
    logic                join_ok;
    logic                leave_ok;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_wdata;
    logic                mem_re;
    logic                pos_end;
    logic [MASK_W-1:0]   cur_bit;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_join     = (i_req.mode == MODE_JOIN);
    assign req_idx     = IDX_W'(i_req.handle);
    assign req_ok      = (HANDLES >= MASK_W) || (int'(i_req.handle) < HANDLES);
    assign join_ok     = req_ok && !r_in_line[req_idx] && (r_count != CNT_W'(HANDLES));
    assign leave_ok    = req_ok && r_in_line[req_idx];
    assign pos_end     = (r_pos == r_count);
    assign cur_bit     = MASK_W'(1) << r_rdata;

    assign mem_we    = (accept && is_join && join_ok)
                    || ((r_state == S_C_EX) && (r_rdata != r_idx));
    assign mem_waddr = (r_state == S_C_EX) ? r_dst[IDX_W-1:0] : r_count[IDX_W-1:0];
    assign mem_wdata = (r_state == S_C_EX) ? r_rdata : req_idx;
    assign mem_re    = ((r_state == S_C_RD) || (r_state == S_W_RD)) && !pos_end;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_line[r_pos[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_in_line     <= '0;
            r_wants_write <= '0;
            r_rd_grant    <= '0;
            r_wr_grant    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_new_rd <= '0;
                        r_new_wr <= '0;
                        r_pos    <= '0;
                        r_dst    <= '0;
                        r_idx    <= req_idx;
                        if (is_join) begin
                            if (join_ok) begin
                                r_status               <= ST_OK;
                                r_count                <= r_count + 1'b1;
                                r_in_line[req_idx]     <= 1'b1;
                                r_wants_write[req_idx] <= i_req.is_write;
                                r_rd_grant[req_idx]    <= 1'b0;
                                r_wr_grant[req_idx]    <= 1'b0;
                                r_state                <= S_W_RD;
                            end else begin
                                r_status <= ST_JOIN_DUP;
                                r_state  <= S_FIN;
                            end
                        end else begin
                            if (leave_ok) begin
                                r_status               <= ST_OK;
                                r_in_line[req_idx]     <= 1'b0;
                                r_wants_write[req_idx] <= 1'b0;
                                r_rd_grant[req_idx]    <= 1'b0;
                                r_wr_grant[req_idx]    <= 1'b0;
                                r_state                <= S_C_RD;
                            end else begin
                                r_status <= ST_LEAVE_ABSENT;
                                r_state  <= S_FIN;
                            end
                        end
                    end
                end
                S_C_RD: begin
                    if (pos_end) begin
                        r_count <= r_dst;
                        r_pos   <= '0;
                        r_state <= S_W_RD;
                    end else begin
                        r_state <= S_C_EX;
                    end
                end
                S_C_EX: begin
                    if (r_rdata != r_idx) begin
                        r_dst <= r_dst + 1'b1;
                    end
                    r_pos   <= r_pos + 1'b1;
                    r_state <= S_C_RD;
                end
                S_W_RD: begin
                    r_state <= pos_end ? S_FIN : S_W_EX;
                end
                S_W_EX: begin
                    if (!r_rd_grant[r_rdata]) begin
                        r_rd_grant[r_rdata] <= 1'b1;
                        r_new_rd            <= r_new_rd | cur_bit;
                    end
                    if (r_wants_write[r_rdata]) begin
                        if ((r_pos == '0) && !r_wr_grant[r_rdata]) begin
                            r_wr_grant[r_rdata] <= 1'b1;
                            r_new_wr            <= r_new_wr | cur_bit;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_W_RD;
                    end
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_load                 = (r_state == S_FIN) && i_out_free;
    assign o_rsp.status           = r_status;
    assign o_rsp.new_read_grants  = r_new_rd;
    assign o_rsp.new_write_grants = r_new_wr;
    assign o_rsp.line_length      = LEN_W'(r_count);

endmodule

`default_nettype wire

>>> src/frwl_out_stage.sv
// Output register that holds a finished result until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module frwl_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire frwl_pkg::t_rsp i_data,
    output logic                o_free,
    frwl_rsp_if.source          o_rsp
);
    import frwl_pkg::*;

    logic r_valid;
    t_rsp r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_free                 = !r_valid || o_rsp.ready;
    assign o_rsp.valid            = r_valid;
    assign o_rsp.status           = r_data.status;
    assign o_rsp.new_read_grants  = r_data.new_read_grants;
    assign o_rsp.new_write_grants = r_data.new_write_grants;
    assign o_rsp.line_length      = r_data.line_length;

endmodule

`default_nettype wire

>>> dv/fifo_reader_writer_lock_grants_core_test.sv
// Self-checking testbench for the FIFO reader-writer lock grant arbiter.
`timescale 1ns / 1ps

module fifo_reader_writer_lock_grants_core_test;
    import frwl_pkg::*;

    localparam int RAND_ITEMS  = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef logic [MASK_W-1:0]   mask_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    class lock_grant_tracker;
        handle_t line_q[HANDLES_DEF];
        int      line_cnt;
        bit      in_line[HANDLES_DEF];
        bit      wants_wr[HANDLES_DEF];
        bit      rd_gnt[HANDLES_DEF];
        bit      wr_gnt[HANDLES_DEF];
        t_rsp    due_grants[$];
        int      errors;
        int      joins;
        int      leaves;
        int      refused;
        int      checked;
        int      peak_len;

        // head-first walk: grant read along the reader prefix, stop at first writer
        function void grant_walk(output mask_t rd, output mask_t wr);
            handle_t h;
            bit      stop;
            rd   = '0;
            wr   = '0;
            stop = 1'b0;
            for (int pos = 0; pos < line_cnt && !stop; pos++) begin
                h = line_q[pos];
                if (!rd_gnt[h]) begin
                    rd_gnt[h] = 1'b1;
                    rd[h]     = 1'b1;
                end
                if (wants_wr[h]) begin
                    if (pos == 0 && !wr_gnt[h]) begin
                        wr_gnt[h] = 1'b1;
                        wr[h]     = 1'b1;
                    end
                    stop = 1'b1;
                end
            end
        endfunction

        function void note_request(logic mode, handle_t h, logic is_wr);
            t_rsp exp;
            int   dst;
            exp        = '0;
            exp.status = ST_OK;
            if (mode == MODE_JOIN) begin
                joins++;
                if (in_line[h] || line_cnt >= HANDLES_DEF) begin
                    exp.status = ST_JOIN_DUP;
                end else begin
                    line_q[line_cnt] = h;
                    line_cnt++;
                    in_line[h]  = 1'b1;
                    wants_wr[h] = is_wr;
                    rd_gnt[h]   = 1'b0;
                    wr_gnt[h]   = 1'b0;
                    grant_walk(exp.new_read_grants, exp.new_write_grants);
                end
            end else begin
                leaves++;
                if (!in_line[h]) begin
                    exp.status = ST_LEAVE_ABSENT;
                end else begin
                    dst = 0;
                    for (int pos = 0; pos < line_cnt; pos++) begin
                        if (line_q[pos] != h) begin
                            line_q[dst] = line_q[pos];
                            dst++;
                        end
                    end
                    line_cnt    = dst;
                    in_line[h]  = 1'b0;
                    wants_wr[h] = 1'b0;
                    rd_gnt[h]   = 1'b0;
                    wr_gnt[h]   = 1'b0;
                    grant_walk(exp.new_read_grants, exp.new_write_grants);
                end
            end
            if (exp.status != ST_OK) refused++;
            exp.line_length = LEN_W'(line_cnt);
            if (line_cnt > peak_len) peak_len = line_cnt;
            due_grants = {due_grants, exp};
        endfunction

        function void check_response(logic [1:0] st, mask_t rd, mask_t wr,
                                     logic [LEN_W-1:0] len);
            t_rsp exp;
            if (due_grants.size() == 0) begin
                errors++;
                $display("%0t: response with no request pending: status %0d rd %h wr %h len %0d",
                         $time, st, rd, wr, len);
                return;
            end
            exp = due_grants.pop_front();
            checked++;
            if (st !== exp.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
            end
            if (rd !== exp.new_read_grants) begin
                errors++;
                $display("%0t: new_read_grants expected %h actual %h",
                         $time, exp.new_read_grants, rd);
            end
            if (wr !== exp.new_write_grants) begin
                errors++;
                $display("%0t: new_write_grants expected %h actual %h",
                         $time, exp.new_write_grants, wr);
            end
            if (len !== exp.line_length) begin
                errors++;
                $display("%0t: line_length expected %0d actual %0d",
                         $time, exp.line_length, len);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    bit   hold_rsp;

    lock_grant_tracker tracker = new();

    frwl_req_if req_if();
    frwl_rsp_if rsp_if();

    fifo_reader_writer_lock_grants_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // valid stays high across back-to-back transactions; it drops only for a gap
    task automatic send_request(logic mode, handle_t h, logic is_wr);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.handle   <= h;
        req_if.is_write <= is_wr;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.note_request(mode, h, is_wr);
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = calm ? 0 : int'($urandom_range(0, 9));
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            tracker.check_response(rsp_if.status, rsp_if.new_read_grants,
                                   rsp_if.new_write_grants, rsp_if.line_length);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** fifo_reader_writer_lock_grants_core: FAILED **");
        $finish;
    end

    initial begin
        logic    mode;
        handle_t h;
        logic    is_wr;
        int      roll;

        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= MODE_JOIN;
        req_if.handle   <= '0;
        req_if.is_write <= 1'b0;
        rsp_if.ready    <= 1'b0;
        calm     = 1'b0;
        hold_rsp = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: leave on empty line, fill to capacity, duplicate join,
        // leave from the middle, writer promoted to head, rejoin behind a writer
        send_request(MODE_LEAVE, 4'd5, 1'b0);
        for (int k = 0; k < HANDLES_DEF; k++)
            send_request(MODE_JOIN, handle_t'(k), (k == 3 || k == 15));
        send_request(MODE_JOIN, 4'd7, 1'b1);
        send_request(MODE_LEAVE, 4'd1, 1'b0);
        send_request(MODE_LEAVE, 4'd0, 1'b0);
        send_request(MODE_LEAVE, 4'd2, 1'b0);
        send_request(MODE_LEAVE, 4'd3, 1'b1);
        send_request(MODE_JOIN, 4'd3, 1'b1);
        send_request(MODE_LEAVE, 4'd15, 1'b0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            calm = ((i / 100) == 2);
            if (i == 150) hold_rsp = 1'b1;
            roll  = int'($urandom_range(0, 99));
            is_wr = ($urandom_range(0, 99) < 30);
            if (roll < 15) begin
                mode = 1'($urandom_range(0, 1));
                h    = handle_t'($urandom_range(0, HANDLES_DEF - 1));
            end else if (tracker.line_cnt == 0 ||
                         (tracker.line_cnt < HANDLES_DEF && roll < 60)) begin
                mode = MODE_JOIN;
                h    = handle_t'($urandom_range(0, HANDLES_DEF - 1));
                while (tracker.in_line[h]) h++;
            end else begin
                mode = MODE_LEAVE;
                if (roll < 75) begin
                    h = tracker.line_q[0];
                end else begin
                    h = handle_t'($urandom_range(0, HANDLES_DEF - 1));
                    while (!tracker.in_line[h]) h++;
                end
            end
            send_request(mode, h, is_wr);
        end
        req_if.valid <= 1'b0;
        calm = 1'b0;

        while (tracker.due_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests (%0d joins, %0d leaves, %0d refused), peak line %0d.",
                 tracker.joins + tracker.leaves, tracker.joins, tracker.leaves,
                 tracker.refused, tracker.peak_len);
        $display("Checked %0d responses with %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.due_grants.size() == 0)
            $display("** fifo_reader_writer_lock_grants_core: PASSED **");
        else
            $display("** fifo_reader_writer_lock_grants_core: FAILED **");
        $finish;
    end

endmodule
